### hw/rtl/fragmented_sparse_array_assert.svh
// Assertion macros for the fragmented sparse array.
`ifndef FRAGMENTED_SPARSE_ARRAY_ASSERT_SVH
`define FRAGMENTED_SPARSE_ARRAY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/fsa_pkg.sv
// Shared types and constants for the fragmented sparse array.
package fsa_pkg;

   // Field widths
   localparam int WORD_W    = 32;
   localparam int CMD_W     = 2;
   localparam int GEOM_W    = 5;
   localparam int CAP_W     = 2 * GEOM_W;
   localparam int REM_W     = GEOM_W + 1;
   localparam int DCNT_W    = 4;
   localparam int FILL_W    = 5;
   localparam int TOTAL_W   = 9;
   localparam int ACT_W     = 5;
   localparam int CSR_IDX_W = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESET = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAG_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER     = 2'd2;

   // Register reset values
   localparam logic [GEOM_W-1:0] FRAG_COUNT_RESET = 5'd16;
   localparam logic [GEOM_W-1:0] CELLS_RESET      = 5'd16;
   localparam logic [WORD_W-1:0] MARKER_RESET     = 32'h8000_0000;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic clear_all;
      logic div_init;
      logic div_step;
      logic addr_latch;
      logic mem_read;
      logic get_latch;
      logic activate;
      logic fill_write;
      logic set_write;
      logic del_commit;
      logic succeed;
      logic fail;
   } fsa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             in_range;
      logic             frag_active;
      logic             cell_empty;
      logic             div_last;
      logic             fill_last;
   } fsa_stat_type;

endpackage

### hw/rtl/fsa_ctrl.sv
// Command sequencer for the fragmented sparse array.
module fsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fsa_pkg::fsa_stat_type stat,
   output fsa_pkg::fsa_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CHECK  = 4'd1;
   localparam logic [3:0] ST_DIV    = 4'd2;
   localparam logic [3:0] ST_ADDR   = 4'd3;
   localparam logic [3:0] ST_READ   = 4'd4;
   localparam logic [3:0] ST_DECIDE = 4'd5;
   localparam logic [3:0] ST_FILL   = 4'd6;
   localparam logic [3:0] ST_SETW   = 4'd7;
   localparam logic [3:0] ST_RESP   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next state and command decode
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.op == fsa_pkg::CMD_RESET) begin
               cmd.clear_all = 1'b1;
               cmd.succeed   = 1'b1;
               state_in      = ST_RESP;
            end else if (!stat.in_range) begin
               cmd.fail = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.addr_latch = 1'b1;
            state_in       = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            case (stat.op)
               fsa_pkg::CMD_GET: begin
                  cmd.get_latch = 1'b1;
                  cmd.succeed   = 1'b1;
               end
               fsa_pkg::CMD_DEL: begin
                  if (stat.frag_active && !stat.cell_empty) begin
                     cmd.del_commit = 1'b1;
                     cmd.succeed    = 1'b1;
                  end else begin
                     cmd.fail = 1'b1;
                  end
               end
               fsa_pkg::CMD_SET: begin
                  if (!stat.frag_active) begin
                     cmd.activate = 1'b1;
                     state_in     = ST_FILL;
                  end else begin
                     cmd.set_write = 1'b1;
                     cmd.succeed   = 1'b1;
                  end
               end
               default: begin
                  cmd.fail = 1'b1;
               end
            endcase
         end
         ST_FILL: begin
            cmd.fill_write = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_SETW;
            end
         end
         ST_SETW: begin
            cmd.set_write = 1'b1;
            cmd.succeed   = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

### hw/rtl/fsa_dpath.sv
// Datapath for the fragmented sparse array: registers, divider, counts, cell store.
module fsa_dpath #(
   parameter int MAX_FRAGMENTS          = 16,
   parameter int MAX_CELLS_PER_FRAGMENT = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fsa_pkg::fsa_cmd_type                  cmd,
   output fsa_pkg::fsa_stat_type                 stat,
   input  logic [fsa_pkg::CMD_W-1:0]             req_command,
   input  logic signed [fsa_pkg::WORD_W-1:0]     req_index,
   input  logic signed [fsa_pkg::WORD_W-1:0]     req_key,
   input  logic                                 csr_we,
   input  logic [fsa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fsa_pkg::WORD_W-1:0]            csr_wdata,
   output logic                                 rsp_status,
   output logic signed [fsa_pkg::WORD_W-1:0]     rsp_read_value,
   output logic [fsa_pkg::TOTAL_W-1:0]           rsp_occupied_cells,
   output logic [fsa_pkg::TOTAL_W-1:0]           rsp_allocated_cells,
   output logic [fsa_pkg::ACT_W-1:0]             rsp_live_fragments
);

   localparam int WORD_W  = fsa_pkg::WORD_W;
   localparam int GEOM_W  = fsa_pkg::GEOM_W;
   localparam int CAP_W   = fsa_pkg::CAP_W;
   localparam int REM_W   = fsa_pkg::REM_W;
   localparam int DCNT_W  = fsa_pkg::DCNT_W;
   localparam int FILL_W  = fsa_pkg::FILL_W;
   localparam int TOTAL_W = fsa_pkg::TOTAL_W;
   localparam int ACT_W   = fsa_pkg::ACT_W;
   localparam int DEPTH   = MAX_FRAGMENTS * MAX_CELLS_PER_FRAGMENT;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FRAG_W  = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

   // Configuration registers
   logic [GEOM_W-1:0] frag_cfg_ff;
   logic [GEOM_W-1:0] cells_cfg_ff;
   logic [WORD_W-1:0] marker_ff;

   // Request registers
   logic [fsa_pkg::CMD_W-1:0] op_ff;
   logic [WORD_W-1:0]         idx_ff;
   logic [WORD_W-1:0]         key_ff;

   // Divider
   logic [CAP_W-1:0]  dvd_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [REM_W-1:0]  trial;
   logic              qbit;

   // Addressing
   logic [FRAG_W-1:0] frag_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [GEOM_W-1:0] fptr_ff;
   logic              fresh_ff;
   logic [ADDR_W-1:0] base_in;

   // Fragment bookkeeping
   logic [MAX_FRAGMENTS-1:0] act_ff;
   logic [FILL_W-1:0]        fill_ff [MAX_FRAGMENTS];
   logic [TOTAL_W-1:0]       total_ff;
   logic [ACT_W-1:0]         live_ff;

   // Cell store
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [WORD_W-1:0] mem_wd;

   // Result registers
   logic              status_ff;
   logic [WORD_W-1:0] rdval_ff;

   // Effective geometry and range check
   logic [GEOM_W-1:0] nf_eff;
   logic [GEOM_W-1:0] cpf_eff;
   logic [CAP_W-1:0]  capacity;
   logic [CAP_W-1:0]  alloc_prod;
   logic              cell_is_marker;

   always_comb begin
      nf_eff = frag_cfg_ff;
      if (frag_cfg_ff == '0) begin
         nf_eff = GEOM_W'(1);
      end else if (32'(frag_cfg_ff) > MAX_FRAGMENTS) begin
         nf_eff = GEOM_W'(MAX_FRAGMENTS);
      end
      cpf_eff = cells_cfg_ff;
      if (cells_cfg_ff == '0) begin
         cpf_eff = GEOM_W'(1);
      end else if (32'(cells_cfg_ff) > MAX_CELLS_PER_FRAGMENT) begin
         cpf_eff = GEOM_W'(MAX_CELLS_PER_FRAGMENT);
      end
   end

   assign capacity   = CAP_W'(nf_eff) * CAP_W'(cpf_eff);
   assign alloc_prod = CAP_W'(live_ff) * CAP_W'(cpf_eff);

   // Restoring divide step: one quotient bit per cycle
   assign trial = {rem_ff[REM_W-2:0], dvd_ff[CAP_W-1]};
   assign qbit  = (trial >= REM_W'(cpf_eff));

   assign base_in        = ADDR_W'(dvd_ff[FRAG_W-1:0]) * ADDR_W'(MAX_CELLS_PER_FRAGMENT);
   assign cell_is_marker = (rd_ff == marker_ff);

   // Status to controller
   always_comb begin
      stat             = '0;
      stat.op          = op_ff;
      stat.in_range    = !idx_ff[WORD_W-1] && (idx_ff[WORD_W-2:CAP_W] == '0)
                         && (idx_ff[CAP_W-1:0] < capacity);
      stat.frag_active = act_ff[frag_ff];
      stat.cell_empty  = fresh_ff || cell_is_marker;
      stat.div_last    = (dcnt_ff == DCNT_W'(1));
      stat.fill_last   = (fptr_ff == (cpf_eff - GEOM_W'(1)));
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frag_cfg_ff  <= fsa_pkg::FRAG_COUNT_RESET;
         cells_cfg_ff <= fsa_pkg::CELLS_RESET;
         marker_ff    <= fsa_pkg::MARKER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fsa_pkg::CSR_FRAG_COUNT: frag_cfg_ff  <= csr_wdata[GEOM_W-1:0];
            fsa_pkg::CSR_CELLS:      cells_cfg_ff <= csr_wdata[GEOM_W-1:0];
            fsa_pkg::CSR_MARKER:     marker_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Request capture, divider, addressing and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_command;
         idx_ff   <= req_index;
         key_ff   <= req_key;
         rdval_ff <= '0;
      end
      if (cmd.div_init) begin
         dvd_ff <= idx_ff[CAP_W-1:0];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[CAP_W-2:0], qbit};
         rem_ff <= qbit ? (trial - REM_W'(cpf_eff)) : trial;
      end
      if (cmd.addr_latch) begin
         frag_ff <= dvd_ff[FRAG_W-1:0];
         base_ff <= base_in;
         addr_ff <= base_in + ADDR_W'(rem_ff);
      end
      if (cmd.get_latch) begin
         rdval_ff <= act_ff[frag_ff] ? rd_ff : marker_ff;
      end
      if (cmd.succeed) begin
         status_ff <= 1'b0;
      end else if (cmd.fail) begin
         status_ff <= 1'b1;
      end
   end

   // Divide and fill counters, fresh-activation flag
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff  <= '0;
         fptr_ff  <= '0;
         fresh_ff <= 1'b0;
      end else begin
         if (cmd.div_init) begin
            dcnt_ff <= DCNT_W'(CAP_W);
         end else if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff - DCNT_W'(1);
         end
         if (cmd.activate) begin
            fptr_ff <= '0;
         end else if (cmd.fill_write) begin
            fptr_ff <= fptr_ff + GEOM_W'(1);
         end
         if (cmd.load) begin
            fresh_ff <= 1'b0;
         end else if (cmd.activate) begin
            fresh_ff <= 1'b1;
         end
      end
   end

   // Fragment flags and occupancy counts
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         act_ff   <= '0;
         total_ff <= '0;
         live_ff  <= '0;
         for (int i = 0; i < MAX_FRAGMENTS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         if (cmd.activate) begin
            act_ff[frag_ff] <= 1'b1;
            live_ff         <= live_ff + ACT_W'(1);
         end
         if (cmd.set_write && stat.cell_empty && (key_ff != marker_ff)) begin
            total_ff         <= total_ff + TOTAL_W'(1);
            fill_ff[frag_ff] <= fill_ff[frag_ff] + FILL_W'(1);
         end
         if (cmd.del_commit) begin
            total_ff         <= total_ff - TOTAL_W'(1);
            fill_ff[frag_ff] <= fill_ff[frag_ff] - FILL_W'(1);
            // last occupied cell gone: free the fragment
            if (fill_ff[frag_ff] == FILL_W'(1)) begin
               act_ff[frag_ff] <= 1'b0;
               live_ff         <= live_ff - ACT_W'(1);
            end
         end
      end
   end

   // Cell store write port select
   assign mem_we = cmd.fill_write || cmd.set_write || cmd.del_commit;
   assign mem_wa = cmd.fill_write ? (base_ff + ADDR_W'(fptr_ff)) : addr_ff;
   assign mem_wd = cmd.set_write ? key_ff : marker_ff;

   // Cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[addr_ff];
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_read_value      = rdval_ff;
   assign rsp_occupied_cells  = total_ff;
   assign rsp_allocated_cells = alloc_prod[TOTAL_W-1:0];
   assign rsp_live_fragments  = live_ff;

endmodule

### hw/rtl/fragmented_sparse_array.sv
// Top level of the fragmented sparse array: sequencer plus datapath.
//
// A command is taken when start is high and busy is low; busy stays high until its
// result has been shown. The result appears on the rsp_ ports for exactly one cycle
// with rsp_valid high and must be captured then, since the receiver cannot stall the
// block. Reset-all and out-of-range commands give their result straight from the
// check state; get, delete and set on an active fragment pass through the index
// divider (one quotient bit per cycle), address latch, cell read and decision
// states; a set that activates a fragment adds the marker fill sweep through
// the single cell store write port. The cell store has no reset and needs no
// clearing pass. Registers are written through the csr_ channel, which is always
// ready, and must be written only while busy is low.
module fragmented_sparse_array #(
   parameter int MAX_FRAGMENTS          = 16,
   parameter int MAX_CELLS_PER_FRAGMENT = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [fsa_pkg::CMD_W-1:0]             req_command,
   input  logic signed [fsa_pkg::WORD_W-1:0]     req_index,
   input  logic signed [fsa_pkg::WORD_W-1:0]     req_key,
   output logic                                 rsp_valid,
   output logic                                 rsp_status,
   output logic signed [fsa_pkg::WORD_W-1:0]     rsp_read_value,
   output logic [fsa_pkg::TOTAL_W-1:0]           rsp_occupied_cells,
   output logic [fsa_pkg::TOTAL_W-1:0]           rsp_allocated_cells,
   output logic [fsa_pkg::ACT_W-1:0]             rsp_live_fragments,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fsa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fsa_pkg::WORD_W-1:0]            csr_wdata
);

`include "fragmented_sparse_array_assert.svh"

   fsa_pkg::fsa_cmd_type  cmd;
   fsa_pkg::fsa_stat_type stat;
   logic                  csr_we;

   // Register channel is always ready
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // Sequencer
   fsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath
   fsa_dpath #(
      .MAX_FRAGMENTS          (MAX_FRAGMENTS),
      .MAX_CELLS_PER_FRAGMENT (MAX_CELLS_PER_FRAGMENT)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_command         (req_command),
      .req_index           (req_index),
      .req_key             (req_key),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_status          (rsp_status),
      .rsp_read_value      (rsp_read_value),
      .rsp_occupied_cells  (rsp_occupied_cells),
      .rsp_allocated_cells (rsp_allocated_cells),
      .rsp_live_fragments  (rsp_live_fragments)
   );

   // Checks
   `FSA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted transaction not busy")
   `FSA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid && !busy, "result not a single strobe")
   `FSA_ASSERT_NOW(a_rsp_in_busy, clock, reset, rsp_valid, busy, "result outside a transaction")
   `FSA_ASSERT_NOW(a_alloc_zero, clock, reset, rsp_valid && (rsp_live_fragments == '0), rsp_allocated_cells == '0, "allocation without live fragments")

endmodule
